[design/bpr_pkg.sv]
package bpr_pkg;

  // Field widths of the transaction payloads
  localparam int OP_W      = 3;
  localparam int USER_W    = 10;
  localparam int ITEM_W    = 12;
  localparam int COL_W     = 5;
  localparam int VAL_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Default table sizes
  localparam int DEF_USERS   = 1024;
  localparam int DEF_ITEMS   = 4096;
  localparam int DEF_FACTORS = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] LEARN_RATE_RST = 16'd655;
  localparam logic [CFG_W-1:0] USER_DECAY_RST = 16'd655;
  localparam logic [CFG_W-1:0] ITEM_DECAY_RST = 16'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE = 2'd0,
    REG_USER_DECAY = 2'd1,
    REG_ITEM_DECAY = 2'd2
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_USER = 3'd0,
    OP_LOAD_ITEM = 3'd1,
    OP_READ_USER = 3'd2,
    OP_READ_ITEM = 3'd3,
    OP_TRAIN     = 3'd4
  } op_t;

  // Classified command, ranges already checked
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD_USER,
    CMD_LOAD_ITEM,
    CMD_READ_USER,
    CMD_READ_ITEM,
    CMD_TRAIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [USER_W-1:0]        user;
    logic [ITEM_W-1:0]        pos_item;
    logic [ITEM_W-1:0]        neg_item;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_LOADP,
    ST_DOT,
    ST_SCORE,
    ST_GAIN,
    ST_UUPD,
    ST_PUPD,
    ST_NUPD,
    ST_RESULT
  } state_t;

  // Clamp to the signed 16 bit range
  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7FFF;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Piecewise linear 1/(1+exp(score)), Q0.16, capped at 65535
  function automatic logic [15:0] neg_sigmoid(input logic signed [15:0] score);
    logic signed [16:0] sx;
    logic [16:0] a;
    logic [17:0] s;
    logic [17:0] g;
    sx = 17'(score);
    a  = score[15] ? 17'(-sx) : 17'(sx);
    if (a >= 17'd20480) s = 18'd65536;
    else if (a >= 17'd9728) s = 18'(a >> 1) + 18'd55296;
    else if (a >= 17'd4096) s = 18'({a, 1'b0}) + 18'd40960;
    else s = 18'({a, 2'b00}) + 18'd32768;
    g = score[15] ? s : 18'd65536 - s;
    return (g > 18'd65535) ? 16'hFFFF : g[15:0];
  endfunction

endpackage

[design/bpr_ifs.sv]
interface bpr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [bpr_pkg::OP_W-1:0]              op;
  logic [bpr_pkg::USER_W-1:0]            user;
  logic [bpr_pkg::ITEM_W-1:0]            pos_item;
  logic [bpr_pkg::ITEM_W-1:0]            neg_item;
  logic [bpr_pkg::COL_W-1:0]             factor_index;
  logic signed [bpr_pkg::VAL_W-1:0]      entry_value;

  modport source (output valid, op, user, pos_item, neg_item, factor_index, entry_value,
                  input ready);
  modport sink   (input valid, op, user, pos_item, neg_item, factor_index, entry_value,
                  output ready);
endinterface

interface bpr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bpr_pkg::VAL_W-1:0] read_value;
  logic signed [bpr_pkg::VAL_W-1:0] score;

  modport source (output valid, read_value, score, input ready);
  modport sink   (input valid, read_value, score, output ready);
endinterface

[design/bpr_ram.sv]
module bpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[design/bpr_front.sv]
module bpr_front #(
  parameter int USERS   = bpr_pkg::DEF_USERS,
  parameter int ITEMS   = bpr_pkg::DEF_ITEMS,
  parameter int FACTORS = bpr_pkg::DEF_FACTORS
) (
  input  logic          clk,
  input  logic          rst,
  bpr_in_if.sink        req,
  output logic          q_valid,
  input  logic          q_pop,
  output bpr_pkg::cmd_t q_cmd
);

  bpr_pkg::cmd_t cls;
  logic user_ok, pos_ok, neg_ok, col_ok;

  // Range checks and op decode
  always_comb begin
    user_ok = 32'(req.user) < USERS;
    pos_ok  = 32'(req.pos_item) < ITEMS;
    neg_ok  = 32'(req.neg_item) < ITEMS;
    col_ok  = 32'(req.factor_index) < FACTORS;
    cls.user     = req.user;
    cls.pos_item = req.pos_item;
    cls.neg_item = req.neg_item;
    cls.col      = req.factor_index;
    cls.value    = req.entry_value;
    cls.kind     = bpr_pkg::CMD_NONE;
    unique case (req.op)
      bpr_pkg::OP_LOAD_USER: if (user_ok && col_ok) cls.kind = bpr_pkg::CMD_LOAD_USER;
      bpr_pkg::OP_LOAD_ITEM: if (pos_ok && col_ok)  cls.kind = bpr_pkg::CMD_LOAD_ITEM;
      bpr_pkg::OP_READ_USER: if (user_ok && col_ok) cls.kind = bpr_pkg::CMD_READ_USER;
      bpr_pkg::OP_READ_ITEM: if (pos_ok && col_ok)  cls.kind = bpr_pkg::CMD_READ_ITEM;
      bpr_pkg::OP_TRAIN:
        if (user_ok && pos_ok && neg_ok) cls.kind = bpr_pkg::CMD_TRAIN;
      default: cls.kind = bpr_pkg::CMD_NONE;
    endcase
  end

  // Two entry queue towards the back end
  bpr_pkg::cmd_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= 2'(count + 2'(push) - 2'(q_pop));
    end
  end

endmodule

[design/bpr_back.sv]
module bpr_back #(
  parameter int USERS   = bpr_pkg::DEF_USERS,
  parameter int ITEMS   = bpr_pkg::DEF_ITEMS,
  parameter int FACTORS = bpr_pkg::DEF_FACTORS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  bpr_pkg::cmd_t                   q_cmd,
  bpr_out_if.source                       rsp
);

  localparam int UDEPTH = USERS * FACTORS;
  localparam int IDEPTH = ITEMS * FACTORS;
  localparam int UAW    = $clog2(UDEPTH);
  localparam int IAW    = $clog2(IDEPTH);
  localparam int FW     = (FACTORS > 1) ? $clog2(FACTORS) : 1;
  localparam int AW     = 34 + FW;

  // Configuration registers
  logic [15:0] learn_rate, user_decay, item_decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= bpr_pkg::LEARN_RATE_RST;
      user_decay <= bpr_pkg::USER_DECAY_RST;
      item_decay <= bpr_pkg::ITEM_DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bpr_pkg::REG_LEARN_RATE: learn_rate <= cfg_data;
        bpr_pkg::REG_USER_DECAY: user_decay <= cfg_data;
        bpr_pkg::REG_ITEM_DECAY: item_decay <= cfg_data;
        default: ;
      endcase
    end
  end

  bpr_pkg::state_t state, state_next;
  bpr_pkg::cmd_t   cmd;
  logic [UAW-1:0]  u_base;
  logic [IAW-1:0]  p_base, n_base;
  logic [FW:0]     kc;
  logic            in_pass, issue, pass_done;

  // Pipeline registers
  logic              v1, va, vb, vc, vd;
  logic [FW-1:0]     k1, ka, kb, kc_s, kd;
  logic signed [33:0] grad_a;
  logic signed [32:0] dec_a;
  logic signed [15:0] old_a, old_b, old_c, new_d;
  logic signed [34:0] inner_b;
  logic signed [51:0] prod_c;
  logic signed [AW-1:0] acc;
  logic signed [15:0] score_r, read_r;
  logic [15:0]        g_r;

  // Memories
  logic           u_we, i_we, pb_we, nb_we;
  logic [UAW-1:0] u_waddr, u_raddr;
  logic [IAW-1:0] i_waddr, i_raddr;
  logic [15:0]    u_wdata, i_wdata, u_rdata, i_rdata, pb_rdata, nb_rdata;
  logic [FW-1:0]  buf_raddr;

  bpr_ram #(.WIDTH(16), .DEPTH(UDEPTH)) u_user_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  bpr_ram #(.WIDTH(16), .DEPTH(IDEPTH)) u_item_ram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rdata)
  );

  // Row buffers for the old positive and negative rows
  bpr_ram #(.WIDTH(16), .DEPTH(FACTORS)) u_pos_buf (
    .clk(clk), .we(pb_we), .waddr(k1), .wdata(i_rdata),
    .raddr(buf_raddr), .rdata(pb_rdata)
  );

  bpr_ram #(.WIDTH(16), .DEPTH(FACTORS)) u_neg_buf (
    .clk(clk), .we(nb_we), .waddr(k1), .wdata(i_rdata),
    .raddr(buf_raddr), .rdata(nb_rdata)
  );

  // Pass control
  always_comb begin
    in_pass = (state == bpr_pkg::ST_LOADP) || (state == bpr_pkg::ST_DOT) ||
              (state == bpr_pkg::ST_UUPD)  || (state == bpr_pkg::ST_PUPD) ||
              (state == bpr_pkg::ST_NUPD);
    issue     = in_pass && (kc < (FW+1)'(FACTORS));
    pass_done = in_pass && (kc == (FW+1)'(FACTORS)) && !v1 && !va && !vb && !vc && !vd;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpr_pkg::ST_IDLE:   if (q_valid && !rsp.valid) state_next = bpr_pkg::ST_EXEC;
      bpr_pkg::ST_EXEC: begin
        case (cmd.kind)
          bpr_pkg::CMD_READ_USER, bpr_pkg::CMD_READ_ITEM: state_next = bpr_pkg::ST_RDWAIT;
          bpr_pkg::CMD_TRAIN: state_next = bpr_pkg::ST_LOADP;
          default: state_next = bpr_pkg::ST_RESULT;
        endcase
      end
      bpr_pkg::ST_RDWAIT: state_next = bpr_pkg::ST_RESULT;
      bpr_pkg::ST_LOADP:  if (pass_done) state_next = bpr_pkg::ST_DOT;
      bpr_pkg::ST_DOT:    if (pass_done) state_next = bpr_pkg::ST_SCORE;
      bpr_pkg::ST_SCORE:  state_next = bpr_pkg::ST_GAIN;
      bpr_pkg::ST_GAIN:   state_next = bpr_pkg::ST_UUPD;
      bpr_pkg::ST_UUPD:   if (pass_done) state_next = bpr_pkg::ST_PUPD;
      bpr_pkg::ST_PUPD:   if (pass_done) state_next = bpr_pkg::ST_NUPD;
      bpr_pkg::ST_NUPD:   if (pass_done) state_next = bpr_pkg::ST_RESULT;
      bpr_pkg::ST_RESULT: state_next = bpr_pkg::ST_IDLE;
      default:            state_next = bpr_pkg::ST_IDLE;
    endcase
  end

  // Memory control outputs
  always_comb begin
    q_pop     = 1'b0;
    u_we      = 1'b0;
    i_we      = 1'b0;
    pb_we     = 1'b0;
    nb_we     = 1'b0;
    u_waddr   = UAW'(u_base + UAW'(kd));
    u_wdata   = new_d;
    i_waddr   = IAW'(p_base + IAW'(kd));
    i_wdata   = new_d;
    u_raddr   = UAW'(u_base + UAW'(kc));
    i_raddr   = IAW'(n_base + IAW'(kc));
    buf_raddr = kc[FW-1:0];
    unique case (state)
      bpr_pkg::ST_IDLE: q_pop = q_valid && !rsp.valid;
      bpr_pkg::ST_EXEC: begin
        u_raddr = UAW'(u_base + UAW'(cmd.col));
        i_raddr = IAW'(p_base + IAW'(cmd.col));
        u_waddr = UAW'(u_base + UAW'(cmd.col));
        i_waddr = IAW'(p_base + IAW'(cmd.col));
        u_wdata = cmd.value;
        i_wdata = cmd.value;
        u_we    = (cmd.kind == bpr_pkg::CMD_LOAD_USER);
        i_we    = (cmd.kind == bpr_pkg::CMD_LOAD_ITEM);
      end
      bpr_pkg::ST_LOADP: begin
        i_raddr = IAW'(p_base + IAW'(kc));
        pb_we   = v1;
      end
      bpr_pkg::ST_DOT:  nb_we = v1;
      bpr_pkg::ST_UUPD: u_we  = vd;
      bpr_pkg::ST_PUPD: i_we  = vd;
      bpr_pkg::ST_NUPD: begin
        i_we    = vd;
        i_waddr = IAW'(n_base + IAW'(kd));
      end
      default: ;
    endcase
  end

  // Operand selection for the multiply stage
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  logic signed [15:0] old_sel;
  logic [15:0]        decay_sel;
  logic signed [32:0] dec_p;

  always_comb begin
    mul_a     = 17'(signed'(g_r)) & 17'h0FFFF;
    mul_b     = 17'(signed'(u_rdata));
    old_sel   = signed'(u_rdata);
    decay_sel = item_decay;
    case (state)
      bpr_pkg::ST_DOT: begin
        mul_a = 17'(signed'(u_rdata));
        mul_b = 17'(signed'(pb_rdata)) - 17'(signed'(i_rdata));
      end
      bpr_pkg::ST_UUPD: begin
        mul_b     = 17'(signed'(pb_rdata)) - 17'(signed'(nb_rdata));
        decay_sel = user_decay;
      end
      bpr_pkg::ST_PUPD: old_sel = signed'(pb_rdata);
      bpr_pkg::ST_NUPD: old_sel = signed'(i_rdata);
      default: ;
    endcase
    mul_p = 34'(mul_a) * 34'(mul_b);
    dec_p = 33'(signed'({1'b0, decay_sel})) * 33'(old_sel);
  end

  // Rounding, scoring and update arithmetic
  logic signed [AW:0]  acc_rnd;
  logic signed [52:0]  prod_rnd;
  logic signed [21:0]  upd_sum;

  always_comb begin
    acc_rnd  = (AW+1)'(acc) + (AW+1)'(2048);
    prod_rnd = 53'(prod_c) + 53'sh80000000;
    upd_sum  = 22'(signed'(prod_rnd[52:32])) + 22'(old_c);
  end

  always_ff @(posedge clk) begin
    // stage 1: read data
    k1 <= kc[FW-1:0];
    // stage A: multiplies
    ka     <= k1;
    grad_a <= (state == bpr_pkg::ST_NUPD) ? -mul_p : mul_p;
    dec_a  <= dec_p;
    old_a  <= old_sel;
    // stage B: gradient minus decay
    kb      <= ka;
    inner_b <= 35'(grad_a) - 35'(dec_a);
    old_b   <= old_a;
    // stage C: learning rate
    kc_s   <= kb;
    prod_c <= 52'(signed'({1'b0, learn_rate})) * 52'(inner_b);
    old_c  <= old_b;
    // stage D: round and clamp
    kd    <= kc_s;
    new_d <= bpr_pkg::sat16(48'(upd_sum));
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpr_pkg::ST_IDLE;
      kc        <= '0;
      v1        <= 1'b0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (issue) kc <= (FW+1)'(kc + 1'b1);
      else if (!in_pass || pass_done) kc <= '0;
      v1 <= issue;
      va <= v1 && (state != bpr_pkg::ST_LOADP);
      vb <= va && (state != bpr_pkg::ST_DOT);
      vc <= vb;
      vd <= vc;
      if (state == bpr_pkg::ST_RESULT) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // Command, bases and result values
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd     <= q_cmd;
      u_base  <= UAW'(32'(q_cmd.user) * FACTORS);
      p_base  <= IAW'(32'(q_cmd.pos_item) * FACTORS);
      n_base  <= IAW'(32'(q_cmd.neg_item) * FACTORS);
      score_r <= '0;
      read_r  <= '0;
      acc     <= '0;
    end
    if (state == bpr_pkg::ST_DOT && va) acc <= AW'(acc + AW'(grad_a));
    if (state == bpr_pkg::ST_RDWAIT)
      read_r <= (cmd.kind == bpr_pkg::CMD_READ_USER) ? signed'(u_rdata) : signed'(i_rdata);
    if (state == bpr_pkg::ST_SCORE) score_r <= bpr_pkg::sat16(48'(acc_rnd >>> 12));
    if (state == bpr_pkg::ST_GAIN) g_r <= bpr_pkg::neg_sigmoid(score_r);
    if (state == bpr_pkg::ST_RESULT) begin
      rsp.read_value <= read_r;
      rsp.score      <= score_r;
    end
  end

endmodule

[design/bpr_factor_sgd_step.sv]
// Channel | Dir | Transaction
// req     | in  | op, user, pos_item, neg_item, factor_index, entry_value
// rsp     | out | read_value, score (one per request)
// cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// Element load/read ops touch a single table entry in the back end. A train
// step runs five passes over the row through the single read port of the
// item table. Reset is synchronous and clears control only; the factor
// tables hold garbage until loaded. The two-entry front queue takes requests
// while the back end works or while a result waits on a stalled rsp, until
// it is full.
module bpr_factor_sgd_step #(
  parameter int USERS   = bpr_pkg::DEF_USERS,
  parameter int ITEMS   = bpr_pkg::DEF_ITEMS,
  parameter int FACTORS = bpr_pkg::DEF_FACTORS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpr_pkg::CFG_W-1:0]     cfg_data,
  bpr_in_if.sink                        req,
  bpr_out_if.source                     rsp
);

  logic          q_valid, q_pop;
  bpr_pkg::cmd_t q_cmd;

  bpr_front #(.USERS(USERS), .ITEMS(ITEMS), .FACTORS(FACTORS)) u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  bpr_back #(.USERS(USERS), .ITEMS(ITEMS), .FACTORS(FACTORS)) u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .rsp(rsp)
  );

endmodule

[test/tb_bpr_factor_sgd_step.sv]
`timescale 1ns / 100ps

module tb_bpr_factor_sgd_step;
  import bpr_pkg::*;

  localparam int FACTORS    = DEF_FACTORS;
  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE     = 250;
  localparam int RAND_ITEMS = 105;
  localparam int PHASES     = 5;

  // Op codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [USER_W-1:0]        user;
    logic [ITEM_W-1:0]        pos_item;
    logic [ITEM_W-1:0]        neg_item;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
    bit                       typed;
    logic signed [VAL_W-1:0]  want_read;
    logic signed [VAL_W-1:0]  want_score;
  } stim_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic signed [VAL_W-1:0] score;
  } rsp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bpr_in_if  req_if ();
  bpr_out_if rsp_if ();

  bpr_factor_sgd_step dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // Shadow copy of the factor tables and registers
  logic signed [15:0] user_tab [int];
  logic signed [15:0] item_tab [int];
  logic [15:0] lr, ru, ri;

  int pool_users [$];
  int pool_items [$];
  int known_users [$];
  int known_items [$];
  rsp_t pending_rsp [$];
  int errors;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // 1/(1+exp(score)) as a Q0.16 gain
  function automatic longint train_gain(input longint sc);
    longint a, s, g;
    a = sc < 0 ? -sc : sc;
    if (a >= 20480) s = 65536;
    else if (a >= 9728) s = (a >>> 1) + 55296;
    else if (a >= 4096) s = 2 * a + 40960;
    else s = 4 * a + 32768;
    g = sc < 0 ? s : 65536 - s;
    return g > 65535 ? 65535 : g;
  endfunction

  function automatic logic signed [15:0] sgd_elem(input longint old, input longint grad,
                                                  input longint decay);
    longint inner, prod;
    inner = grad - decay * old;
    prod  = longint'(lr) * inner;
    return 16'(sat16(old + ((prod + 64'sd2147483648) >>> 32)));
  endfunction

  function automatic logic signed [15:0] tab_get(input bit is_user, input int key);
    if (is_user) return user_tab.exists(key) ? user_tab[key] : 16'sd0;
    return item_tab.exists(key) ? item_tab[key] : 16'sd0;
  endfunction

  // Work out the response to one request and update the shadow tables
  function automatic rsp_t predict_factor_step(input stim_t s);
    rsp_t r;
    int ub, pb, nb;
    longint acc, sc, g, d;
    r.read_value = '0;
    r.score = '0;
    ub = int'(s.user) * FACTORS;
    pb = int'(s.pos_item) * FACTORS;
    nb = int'(s.neg_item) * FACTORS;
    case (s.op)
      OP_LOAD_USER: user_tab[ub + s.col] = s.value;
      OP_LOAD_ITEM: item_tab[pb + s.col] = s.value;
      OP_READ_USER: r.read_value = tab_get(1, ub + s.col);
      OP_READ_ITEM: r.read_value = tab_get(0, pb + s.col);
      OP_TRAIN: begin
        acc = 0;
        for (int k = 0; k < FACTORS; k++)
          acc += longint'(tab_get(1, ub + k)) *
                 (longint'(tab_get(0, pb + k)) - longint'(tab_get(0, nb + k)));
        sc = sat16((acc + 2048) >>> 12);
        r.score = 16'(sc);
        g = train_gain(sc);
        for (int k = 0; k < FACTORS; k++) begin
          d = longint'(tab_get(0, pb + k)) - longint'(tab_get(0, nb + k));
          user_tab[ub + k] = sgd_elem(tab_get(1, ub + k), g * d, ru);
        end
        for (int k = 0; k < FACTORS; k++)
          item_tab[pb + k] = sgd_elem(tab_get(0, pb + k), g * tab_get(1, ub + k), ri);
        // negative row sees the new positive row when both are the same
        for (int k = 0; k < FACTORS; k++)
          item_tab[nb + k] = sgd_elem(tab_get(0, nb + k), -g * tab_get(1, ub + k), ri);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Present one request, wait for its transaction, record the expectation
  task automatic send_request(input stim_t s);
    rsp_t want;
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= s.op;
    req_if.user         <= s.user;
    req_if.pos_item     <= s.pos_item;
    req_if.neg_item     <= s.neg_item;
    req_if.factor_index <= s.col;
    req_if.entry_value  <= s.value;
    do @(posedge clk); while (!req_if.ready);
    want = predict_factor_step(s);
    if (s.typed) begin
      want.read_value = s.want_read;
      want.score = s.want_score;
    end
    pending_rsp.insert(pending_rsp.size(), want);
    if (s.op == OP_LOAD_USER && !(int'(s.user) inside {pool_users}))
      known_users.insert(known_users.size(), int'(s.user) * FACTORS + s.col);
    if (s.op == OP_LOAD_ITEM && !(int'(s.pos_item) inside {pool_items}))
      known_items.insert(known_items.size(), int'(s.pos_item) * FACTORS + s.col);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LEARN_RATE: lr = data;
      REG_USER_DECAY: ru = data;
      default:        ri = data;
    endcase
  endtask

  task automatic drain_and_settle();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic stim_t blank_stim();
    stim_t s;
    s.op = OP_READ_USER;
    s.user = '0;
    s.pos_item = '0;
    s.neg_item = '0;
    s.col = '0;
    s.value = '0;
    s.typed = 0;
    s.want_read = '0;
    s.want_score = '0;
    return s;
  endfunction

  function automatic stim_t make_stim(input logic [OP_W-1:0] op, input int user,
                                      input int pos, input int neg, input int col,
                                      input int value);
    stim_t s;
    s = blank_stim();
    s.op = op;
    s.user = USER_W'(user);
    s.pos_item = ITEM_W'(pos);
    s.neg_item = ITEM_W'(neg);
    s.col = COL_W'(col);
    s.value = VAL_W'(value);
    return s;
  endfunction

  function automatic stim_t typed_stim(input stim_t s, input int rd, input int sc);
    stim_t t;
    t = s;
    t.typed = 1;
    t.want_read = VAL_W'(rd);
    t.want_score = VAL_W'(sc);
    return t;
  endfunction

  function automatic int rand_value();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 65535) - 32768;
      default: return int'($urandom_range(0, 8191)) - 4096;
    endcase
  endfunction

  // Weighted random request; reads and trains stay on written entries
  function automatic stim_t random_stim();
    stim_t s;
    int pick, key;
    s = blank_stim();
    pick = $urandom_range(0, 99);
    s.user     = USER_W'(pool_users[$urandom_range(0, pool_users.size() - 1)]);
    s.pos_item = ITEM_W'(pool_items[$urandom_range(0, pool_items.size() - 1)]);
    s.neg_item = ITEM_W'(pool_items[$urandom_range(0, pool_items.size() - 1)]);
    s.col      = COL_W'($urandom_range(0, FACTORS - 1));
    s.value    = VAL_W'(rand_value());
    if (pick < 35) begin
      s.op = OP_TRAIN;
      if ($urandom_range(0, 9) == 0) s.neg_item = s.pos_item;
    end else if (pick < 50) begin
      s.op = $urandom_range(0, 1) ? OP_LOAD_USER : OP_LOAD_ITEM;
    end else if (pick < 60) begin
      s.op = $urandom_range(0, 1) ? OP_LOAD_USER : OP_LOAD_ITEM;
      s.user = USER_W'($urandom);
      s.pos_item = ITEM_W'($urandom);
      s.neg_item = ITEM_W'($urandom);
    end else if (pick < 70 && known_users.size() != 0) begin
      s.op = OP_READ_USER;
      key = known_users[$urandom_range(0, known_users.size() - 1)];
      s.user = USER_W'(key / FACTORS);
      s.col = COL_W'(key % FACTORS);
    end else if (pick < 80 && known_items.size() != 0) begin
      s.op = OP_READ_ITEM;
      key = known_items[$urandom_range(0, known_items.size() - 1)];
      s.pos_item = ITEM_W'(key / FACTORS);
      s.col = COL_W'(key % FACTORS);
    end else if (pick < 93) begin
      s.op = $urandom_range(0, 1) ? OP_READ_USER : OP_READ_ITEM;
    end else begin
      s.op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      s.user = USER_W'($urandom);
      s.pos_item = ITEM_W'($urandom);
    end
    return s;
  endfunction

  // Response checker with random back-pressure
  initial begin
    rsp_t want;
    int stall;
    rsp_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if (pending_rsp.size() == 0) begin
        report("response with nothing outstanding");
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.read_value !== want.read_value)
          report($sformatf("read_value %0d, want %0d", rsp_if.read_value, want.read_value));
        if (rsp_if.score !== want.score)
          report($sformatf("score %0d, want %0d", rsp_if.score, want.score));
      end
    end
  end

  // Watchdog on transaction progress
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || rst)
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    stim_t directed [$];
    stim_t s;
    errors = 0;
    steady = 0;
    lr = LEARN_RATE_RST;
    ru = USER_DECAY_RST;
    ri = ITEM_DECAY_RST;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.op = OP_LOAD_USER;
    req_if.user = '0;
    req_if.pos_item = '0;
    req_if.neg_item = '0;
    req_if.factor_index = '0;
    req_if.entry_value = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pool_users = '{0, 3, 4, 1023};
    pool_items = '{0, 5, 8, 9, 4094, 4095};

    // Fill the training rows so nothing unwritten is ever read
    foreach (pool_users[i])
      for (int k = 0; k < FACTORS; k++)
        send_request(make_stim(OP_LOAD_USER, pool_users[i], 0, 0, k,
                               int'($urandom_range(0, 4095)) - 2048));
    foreach (pool_items[i])
      for (int k = 0; k < FACTORS; k++)
        send_request(make_stim(OP_LOAD_ITEM, 0, pool_items[i], 0, k,
                               int'($urandom_range(0, 4095)) - 2048));

    // Directed: extremes, every op, spare ops, same pos and neg item
    s = make_stim(OP_LOAD_USER, 1023, 0, 0, 31, -32768);
    directed.insert(directed.size(), typed_stim(s, 0, 0));
    s = make_stim(OP_READ_USER, 1023, 0, 0, 31, 0);
    directed.insert(directed.size(), typed_stim(s, -32768, 0));
    s = make_stim(OP_LOAD_ITEM, 0, 4095, 0, 0, 32767);
    directed.insert(directed.size(), typed_stim(s, 0, 0));
    s = make_stim(OP_READ_ITEM, 0, 4095, 0, 0, 0);
    directed.insert(directed.size(), typed_stim(s, 32767, 0));
    s = make_stim(OP_LOAD_USER, 0, 0, 0, 0, 0);
    directed.insert(directed.size(), typed_stim(s, 0, 0));
    s = make_stim(OP_READ_USER, 0, 0, 0, 0, 0);
    directed.insert(directed.size(), typed_stim(s, 0, 0));
    s = make_stim(OP_LOAD_ITEM, 0, 0, 0, 31, -1);
    directed.insert(directed.size(), typed_stim(s, 0, 0));
    s = make_stim(OP_READ_ITEM, 0, 0, 4095, 31, 0);
    directed.insert(directed.size(), typed_stim(s, -1, 0));
    s = make_stim(OP_SPARE_A, 1023, 4095, 4095, 31, -1);
    directed.insert(directed.size(), typed_stim(s, 0, 0));
    s = make_stim(OP_SPARE_B, 0, 0, 0, 0, 32767);
    directed.insert(directed.size(), typed_stim(s, 0, 0));
    s = make_stim(OP_SPARE_C, 1023, 4095, 0, 31, -32768);
    directed.insert(directed.size(), typed_stim(s, 0, 0));
    // identical positive and negative rows give a zero score
    s = make_stim(OP_TRAIN, 3, 5, 5, 0, 0);
    directed.insert(directed.size(), typed_stim(s, 0, 0));
    directed.insert(directed.size(), make_stim(OP_TRAIN, 1023, 4095, 0, 0, 0));
    directed.insert(directed.size(), make_stim(OP_TRAIN, 1023, 0, 4095, 0, 0));
    directed.insert(directed.size(), make_stim(OP_TRAIN, 0, 4094, 4095, 31, 0));
    // saturated rows push the score and updates to their limits
    for (int k = 0; k < 4; k++) begin
      directed.insert(directed.size(), make_stim(OP_LOAD_USER, 4, 0, 0, k, 32767));
      directed.insert(directed.size(), make_stim(OP_LOAD_ITEM, 0, 8, 0, k, 32767));
    end
    directed.insert(directed.size(), make_stim(OP_TRAIN, 4, 8, 9, 0, 0));
    directed.insert(directed.size(), make_stim(OP_TRAIN, 4, 9, 8, 0, 0));
    foreach (directed[i]) send_request(directed[i]);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_settle();
      case (ph)
        0: begin
          write_reg(REG_LEARN_RATE, 16'hFFFF);
          write_reg(REG_USER_DECAY, 16'h0000);
          write_reg(REG_ITEM_DECAY, 16'h0000);
        end
        1: begin
          write_reg(REG_LEARN_RATE, 16'h0000);
          write_reg(REG_USER_DECAY, 16'hFFFF);
          write_reg(REG_ITEM_DECAY, 16'hFFFF);
        end
        2: begin
          write_reg(REG_LEARN_RATE, 16'($urandom));
          write_reg(REG_USER_DECAY, 16'($urandom));
          write_reg(REG_ITEM_DECAY, 16'($urandom));
        end
        3: begin
          write_reg(REG_LEARN_RATE, 16'hFFFF);
          write_reg(REG_USER_DECAY, 16'hFFFF);
          write_reg(REG_ITEM_DECAY, 16'hFFFF);
        end
        default: begin
          write_reg(REG_LEARN_RATE, LEARN_RATE_RST);
          write_reg(REG_USER_DECAY, USER_DECAY_RST);
          write_reg(REG_ITEM_DECAY, ITEM_DECAY_RST);
        end
      endcase
      for (int i = 0; i < RAND_ITEMS / PHASES; i++) begin
        // stretches with no idling on either side
        if (i % 30 == 0) steady = ($urandom_range(0, 3) == 0);
        send_request(random_stim());
      end
      steady = 0;
    end

    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
design/bpr_pkg.sv
design/bpr_ifs.sv
design/bpr_ram.sv
design/bpr_front.sv
design/bpr_back.sv
design/bpr_factor_sgd_step.sv
test/tb_bpr_factor_sgd_step.sv
